// File: design/tbd_pkg.sv
// Shared types and constants for the touch button debounce block.
// Used by tbd_hit_test, tbd_fsm and touch_button_debounce_fsm; no dependencies.
package tbd_pkg;

  localparam int BOX_SIZE    = 80;
  localparam int MAX_TOUCHES = 4;
  localparam int NUM_POINTS  = 4;

  localparam int COORD_W = 11;
  localparam int TIME_W  = 32;
  localparam int DEB_W   = 16;
  localparam int CNT_W   = 3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Input item layout inside tdata, lowest bit first.
  localparam int ITEM_W      = TIME_W + CNT_W + 2 * NUM_POINTS * COORD_W + 1;
  localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
  localparam int POINTS_LSB  = TIME_W + CNT_W;
  localparam int SET_ON_BIT  = ITEM_W - 1;
  localparam int RESULT_W    = 7;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_NORMAL        = 3'd0,
    ST_PRESSED       = 3'd1,
    ST_DEBOUNCED     = 3'd2,
    ST_IND           = 3'd3,
    ST_IND_PRESSED   = 3'd4,
    ST_IND_DEBOUNCED = 3'd5
  } btn_state_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BOX_LEFT  = 2'd0,
    CFG_BOX_TOP   = 2'd1,
    CFG_LATCHING  = 2'd2,
    CFG_DEBOUNCE  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_POLL      = 1'b0,
    CMD_FORCE_IND = 1'b1
  } cmd_t;

  localparam logic [1:0] TILE_NORMAL      = 2'd0;
  localparam logic [1:0] TILE_PRESSED     = 2'd1;
  localparam logic [1:0] TILE_IND         = 2'd2;
  localparam logic [1:0] TILE_IND_PRESSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic               latching;
    logic [DEB_W-1:0]   debounce_ms;
  } tbd_cfg_t;

  // Packed so that press_confirmed lands in bit 0 of out_tdata.
  typedef struct packed {
    logic       touched;
    logic       indicator_on;
    logic       beep_request;
    logic [1:0] tile_index;
    logic       redraw;
    logic       press_confirmed;
  } tbd_result_t;

endpackage

// File: design/touch_button_debounce_fsm.sv
// An accepted transaction is held in the input register, and its result goes to
// the result register once that is free. Throughput: one transaction per cycle
// unless out_tready stalls; the state update between the registers sets that rate.
// Reset (rst_n, synchronous, active low) empties both registers, returns the
// button to its normal state with a zero touch start time, and loads defaults.
// Top level of the touch button debounce block; depends on tbd_pkg,
// tbd_hit_test and tbd_fsm.
module touch_button_debounce_fsm
  import tbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg_wdata: box_left, box_top, latching_mode or debounce_ms, by cfg_addr
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata from bit 0: now_ms, touch_count, touch_x0, touch_y0, touch_x1,
  // touch_y1, touch_x2, touch_y2, touch_x3, touch_y3, set_on, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata from bit 0: press_confirmed, redraw, tile_index, beep_request,
  // indicator_on, touched, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  tbd_cfg_t           cfg_r;
  logic               s1_valid_r;
  logic [ITEM_W-1:0]  s1_item_r;
  logic               s1_cmd_r;
  logic               out_valid_r;
  tbd_result_t        res_r;
  tbd_result_t        res_nxt;
  logic               out_free;
  logic               step;
  logic               hit;
  logic [COORD_W-1:0] xs [NUM_POINTS];
  logic [COORD_W-1:0] ys [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_left    <= '0;
      cfg_r.box_top     <= '0;
      cfg_r.latching    <= 1'b0;
      cfg_r.debounce_ms <= DEB_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_BOX_LEFT: cfg_r.box_left    <= cfg_wdata[COORD_W-1:0];
        CFG_BOX_TOP:  cfg_r.box_top     <= cfg_wdata[COORD_W-1:0];
        CFG_LATCHING: cfg_r.latching    <= cfg_wdata[0];
        CFG_DEBOUNCE: cfg_r.debounce_ms <= cfg_wdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // The result register frees up when empty or when its transaction is taken.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_tdata[ITEM_W-1:0];
      s1_cmd_r  <= in_tuser;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      xs[i] = s1_item_r[POINTS_LSB + 2*i*COORD_W +: COORD_W];
      ys[i] = s1_item_r[POINTS_LSB + (2*i+1)*COORD_W +: COORD_W];
    end
  end

  tbd_hit_test u_hit (
    .box_left_i    (cfg_r.box_left),
    .box_top_i     (cfg_r.box_top),
    .touch_count_i (s1_item_r[TIME_W +: CNT_W]),
    .x_i           (xs),
    .y_i           (ys),
    .hit_o         (hit)
  );

  tbd_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step),
    .cmd_i     (s1_cmd_r),
    .set_on_i  (s1_item_r[SET_ON_BIT]),
    .now_i     (s1_item_r[TIME_W-1:0]),
    .touched_i (hit),
    .cfg_i     (cfg_r),
    .res_o     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, res_r};

`ifndef NO_ASSERTIONS
  // A result without a redraw carries tile zero.
  a_tile_needs_redraw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.redraw |-> res_r.tile_index == TILE_NORMAL)
    else $error("tile index set without redraw");

  // A confirmed press always redraws and never beeps in the same transaction.
  a_press_redraws: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.press_confirmed |-> res_r.redraw && !res_r.beep_request)
    else $error("press confirmed without redraw or with beep");

  // A beep only comes from a held touch and shows a pressed tile.
  a_beep_touched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.beep_request |->
      res_r.touched && res_r.redraw &&
      (res_r.tile_index == TILE_PRESSED || res_r.tile_index == TILE_IND_PRESSED))
    else $error("beep without touch or pressed tile");

  // Backpressure at the input only when both registers are occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free register");
`endif

endmodule

// File: design/tbd_hit_test.sv
// Hit test of up to four touch points against the button's square box.
// Depends on tbd_pkg.
module tbd_hit_test
  import tbd_pkg::*;
(
  input  logic [COORD_W-1:0] box_left_i,
  input  logic [COORD_W-1:0] box_top_i,
  input  logic [CNT_W-1:0]   touch_count_i,
  input  logic [COORD_W-1:0] x_i [NUM_POINTS],
  input  logic [COORD_W-1:0] y_i [NUM_POINTS],
  output logic               hit_o
);

  localparam int LIMIT = (MAX_TOUCHES > NUM_POINTS) ? NUM_POINTS : MAX_TOUCHES;

  logic [COORD_W:0] xmax;
  logic [COORD_W:0] ymax;

  // The box edges are computed one bit wider so they never wrap.
  assign xmax = {1'b0, box_left_i} + (COORD_W+1)'(BOX_SIZE);
  assign ymax = {1'b0, box_top_i} + (COORD_W+1)'(BOX_SIZE);

  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (i < LIMIT && CNT_W'(i) < touch_count_i) begin
        if (x_i[i] >= box_left_i && {1'b0, x_i[i]} <= xmax &&
            y_i[i] >= box_top_i && {1'b0, y_i[i]} <= ymax) begin
          hit_o = 1'b1;
        end
      end
    end
  end

endmodule

// File: design/tbd_fsm.sv
// Six-state debounce machine with momentary and latching behavior.
// Depends on tbd_pkg; advances once per step.
module tbd_fsm
  import tbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic              cmd_i,
  input  logic              set_on_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic              touched_i,
  input  tbd_cfg_t          cfg_i,
  output tbd_result_t       res_o
);

  btn_state_t        state_r, state_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              long_enough;

  // Wrap-safe elapsed time.
  assign elapsed     = now_i - start_r;
  assign long_enough = elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg_i.debounce_ms};

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    if (cmd_i == CMD_FORCE_IND) begin
      if (cfg_i.latching) begin
        state_nxt = set_on_i ? ST_IND : ST_NORMAL;
      end
    end else begin
      unique case (state_r)
        ST_PRESSED: begin
          if (!touched_i) begin
            state_nxt = ST_NORMAL;
          end else if (long_enough) begin
            state_nxt = ST_DEBOUNCED;
          end
        end
        ST_DEBOUNCED: begin
          if (!touched_i) begin
            state_nxt = cfg_i.latching ? ST_IND : ST_NORMAL;
          end
        end
        ST_IND: begin
          if (touched_i) begin
            start_nxt = now_i;
            state_nxt = ST_IND_PRESSED;
          end
        end
        ST_IND_PRESSED: begin
          if (!touched_i) begin
            state_nxt = ST_IND;
          end else if (long_enough) begin
            state_nxt = ST_IND_DEBOUNCED;
          end
        end
        ST_IND_DEBOUNCED: begin
          if (!touched_i) begin
            state_nxt = ST_NORMAL;
          end
        end
        default: begin
          if (touched_i) begin
            start_nxt = now_i;
            state_nxt = ST_PRESSED;
          end else begin
            state_nxt = ST_NORMAL;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    if (cmd_i == CMD_FORCE_IND) begin
      if (cfg_i.latching) begin
        res_o.redraw     = 1'b1;
        res_o.tile_index = set_on_i ? TILE_IND : TILE_NORMAL;
      end
    end else begin
      res_o.touched = touched_i;
      unique case (state_r)
        ST_PRESSED: begin
          if (!touched_i) begin
            res_o.redraw = 1'b1;
          end else if (long_enough) begin
            res_o.redraw       = 1'b1;
            res_o.tile_index   = TILE_PRESSED;
            res_o.beep_request = 1'b1;
          end
        end
        ST_DEBOUNCED: begin
          if (!touched_i) begin
            res_o.press_confirmed = 1'b1;
            res_o.redraw          = 1'b1;
            res_o.tile_index      = cfg_i.latching ? TILE_IND : TILE_NORMAL;
          end
        end
        ST_IND_PRESSED: begin
          if (!touched_i) begin
            res_o.redraw     = 1'b1;
            res_o.tile_index = TILE_IND;
          end else if (long_enough) begin
            res_o.redraw       = 1'b1;
            res_o.tile_index   = TILE_IND_PRESSED;
            res_o.beep_request = 1'b1;
          end
        end
        ST_IND_DEBOUNCED: begin
          if (!touched_i) begin
            res_o.press_confirmed = 1'b1;
            res_o.redraw          = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res_o.indicator_on = (state_nxt == ST_IND) || (state_nxt == ST_IND_PRESSED) ||
                         (state_nxt == ST_IND_DEBOUNCED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
      start_r <= '0;
    end else if (step_i) begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A force command never moves the touch start time.
  a_force_keeps_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && cmd_i == CMD_FORCE_IND |=> $stable(start_r))
    else $error("force command changed touch start time");

  // In momentary mode a force command leaves the state alone.
  a_force_momentary: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && cmd_i == CMD_FORCE_IND && !cfg_i.latching |=> $stable(state_r))
    else $error("force command changed state in momentary mode");

  // Without a step nothing in the machine moves.
  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step_i |=> $stable(state_r) && $stable(start_r))
    else $error("state changed without a step");
`endif

endmodule

// File: tb/touch_button_debounce_fsm_test.sv
// Self-checking testbench for touch_button_debounce_fsm: directed table, then random phases.
// A predictor tracks the debounce state machine per accepted transaction; depends on tbd_pkg.
module touch_button_debounce_fsm_test;
  import tbd_pkg::*;

  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  localparam int FAR_COORD       = 1024;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES      = 6;

  typedef struct packed {
    cmd_t                               cmd;
    logic [TIME_W-1:0]                  now_ms;
    logic [CNT_W-1:0]                   count;
    logic [NUM_POINTS-1:0][COORD_W-1:0] px;
    logic [NUM_POINTS-1:0][COORD_W-1:0] py;
    logic                               set_on;
  } poll_t;

  // One line of the directed table: either a register write or a transaction,
  // optionally with its result written out by hand.
  typedef struct packed {
    logic                  is_reg;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    poll_t                 item;
    logic                  typed;
    tbd_result_t           res;
  } step_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  touch_button_debounce_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #4 clk = ~clk;

  // Predictor copy of the registers and of the button state.
  logic [COORD_W-1:0] box_left = '0;
  logic [COORD_W-1:0] box_top = '0;
  logic               latching = 1'b0;
  logic [DEB_W-1:0]   debounce_ms = 16'd50;
  btn_state_t         btn_state = ST_NORMAL;
  logic [TIME_W-1:0]  touch_start_ms = '0;

  tbd_result_t results_due[$];
  step_row_t   directed_rows[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_off_req = 1'b0;
  int items_sent = 0;
  int results_checked = 0;
  int confirmed_presses = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Random sequence state: a finger goes down or up for a short run of polls.
  bit                finger_down = 1'b0;
  int                run_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic logic point_in_box(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    logic [COORD_W:0] xmax;
    logic [COORD_W:0] ymax;
    xmax = {1'b0, box_left} + (COORD_W+1)'(BOX_SIZE);
    ymax = {1'b0, box_top} + (COORD_W+1)'(BOX_SIZE);
    return (x >= box_left) && ({1'b0, x} <= xmax) && (y >= box_top) && ({1'b0, y} <= ymax);
  endfunction

  function automatic logic any_hit(poll_t it);
    int  n;
    logic hit;
    n = int'(it.count);
    if (n > MAX_TOUCHES) n = MAX_TOUCHES;
    if (n > NUM_POINTS) n = NUM_POINTS;
    hit = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (point_in_box(it.px[k], it.py[k])) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic tbd_result_t advance_button(poll_t it);
    tbd_result_t       r;
    logic [TIME_W-1:0] elapsed;
    logic              long_enough;
    r = '0;
    if (it.cmd == CMD_FORCE_IND) begin
      if (latching) begin
        r.redraw = 1'b1;
        if (it.set_on) begin
          btn_state = ST_IND;
          r.tile_index = TILE_IND;
        end else begin
          btn_state = ST_NORMAL;
          r.tile_index = TILE_NORMAL;
        end
      end
    end else begin
      // Wrap-safe: the subtraction is modulo 2^32.
      elapsed = it.now_ms - touch_start_ms;
      long_enough = elapsed > debounce_ms;
      r.touched = any_hit(it);
      case (btn_state)
        ST_PRESSED: begin
          if (r.touched) begin
            if (long_enough) begin
              btn_state = ST_DEBOUNCED;
              r.redraw = 1'b1;
              r.tile_index = TILE_PRESSED;
              r.beep_request = 1'b1;
            end
          end else begin
            btn_state = ST_NORMAL;
            r.redraw = 1'b1;
            r.tile_index = TILE_NORMAL;
          end
        end
        ST_DEBOUNCED: begin
          if (!r.touched) begin
            r.press_confirmed = 1'b1;
            r.redraw = 1'b1;
            if (latching) begin
              btn_state = ST_IND;
              r.tile_index = TILE_IND;
            end else begin
              btn_state = ST_NORMAL;
              r.tile_index = TILE_NORMAL;
            end
          end
        end
        ST_IND: begin
          if (r.touched) begin
            touch_start_ms = it.now_ms;
            btn_state = ST_IND_PRESSED;
          end
        end
        ST_IND_PRESSED: begin
          if (r.touched) begin
            if (long_enough) begin
              btn_state = ST_IND_DEBOUNCED;
              r.redraw = 1'b1;
              r.tile_index = TILE_IND_PRESSED;
              r.beep_request = 1'b1;
            end
          end else begin
            btn_state = ST_IND;
            r.redraw = 1'b1;
            r.tile_index = TILE_IND;
          end
        end
        ST_IND_DEBOUNCED: begin
          if (!r.touched) begin
            btn_state = ST_NORMAL;
            r.press_confirmed = 1'b1;
            r.redraw = 1'b1;
            r.tile_index = TILE_NORMAL;
          end
        end
        default: begin
          if (r.touched) begin
            touch_start_ms = it.now_ms;
            btn_state = ST_PRESSED;
          end else begin
            btn_state = ST_NORMAL;
          end
        end
      endcase
    end
    r.indicator_on = (btn_state == ST_IND) || (btn_state == ST_IND_PRESSED) ||
                     (btn_state == ST_IND_DEBOUNCED);
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_poll(poll_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[TIME_W-1:0] = it.now_ms;
    d[TIME_W +: CNT_W] = it.count;
    for (int k = 0; k < NUM_POINTS; k++) begin
      d[POINTS_LSB + 2 * k * COORD_W +: COORD_W] = it.px[k];
      d[POINTS_LSB + (2 * k + 1) * COORD_W +: COORD_W] = it.py[k];
    end
    d[SET_ON_BIT] = it.set_on;
    return d;
  endfunction

  function automatic tbd_result_t outcome(logic press, logic rd, logic [1:0] tile, logic beep,
                                          logic ind, logic hit);
    tbd_result_t r;
    r.press_confirmed = press;
    r.redraw = rd;
    r.tile_index = tile;
    r.beep_request = beep;
    r.indicator_on = ind;
    r.touched = hit;
    return r;
  endfunction

  function automatic step_row_t poll_row(logic [TIME_W-1:0] now, logic [CNT_W-1:0] cnt, int slot,
                                         logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic typed, tbd_result_t r);
    step_row_t s;
    s = '0;
    s.item.cmd = CMD_POLL;
    s.item.now_ms = now;
    s.item.count = cnt;
    for (int k = 0; k < NUM_POINTS; k++) begin
      s.item.px[k] = COORD_W'(FAR_COORD);
      s.item.py[k] = COORD_W'(FAR_COORD);
    end
    s.item.px[slot] = x;
    s.item.py[slot] = y;
    s.typed = typed;
    s.res = r;
    return s;
  endfunction

  function automatic step_row_t force_row(logic on, logic typed, tbd_result_t r);
    step_row_t s;
    s = '0;
    s.item.cmd = CMD_FORCE_IND;
    s.item.set_on = on;
    s.typed = typed;
    s.res = r;
    return s;
  endfunction

  function automatic step_row_t reg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    step_row_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = v;
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] coord_hit(logic [COORD_W-1:0] lo);
    int hi;
    hi = int'(lo) + BOX_SIZE;
    if (hi > COORD_MAX) hi = COORD_MAX;
    return COORD_W'($urandom_range(int'(lo), hi));
  endfunction

  function automatic logic [COORD_W-1:0] coord_miss(logic [COORD_W-1:0] lo);
    int base;
    base = int'(lo);
    if (base > 0 && ($urandom_range(0, 1) == 1 || base + BOX_SIZE + 1 > COORD_MAX))
      return COORD_W'($urandom_range(0, base - 1));
    return COORD_W'($urandom_range(base + BOX_SIZE + 1, COORD_MAX));
  endfunction

  function automatic poll_t make_poll();
    poll_t it;
    int    roll;
    int    live;
    int    slot;
    it = '0;
    roll = $urandom_range(0, 99);
    for (int k = 0; k < NUM_POINTS; k++) begin
      if ($urandom_range(0, 1) == 1) begin
        it.px[k] = coord_miss(box_left);
        it.py[k] = COORD_W'($urandom_range(0, COORD_MAX));
      end else begin
        it.px[k] = COORD_W'($urandom_range(0, COORD_MAX));
        it.py[k] = coord_miss(box_top);
      end
    end
    if (roll < 8) begin
      // Noise: every field drawn at random.
      it.cmd = cmd_t'($urandom_range(0, 1));
      it.now_ms = $urandom;
      it.count = CNT_W'($urandom_range(0, 7));
      for (int k = 0; k < NUM_POINTS; k++) begin
        it.px[k] = COORD_W'($urandom_range(0, COORD_MAX));
        it.py[k] = COORD_W'($urandom_range(0, COORD_MAX));
      end
      it.set_on = 1'($urandom_range(0, 1));
    end else if (roll < 14) begin
      it.cmd = CMD_FORCE_IND;
      it.now_ms = clock_ms;
      it.set_on = 1'($urandom_range(0, 1));
    end else begin
      it.cmd = CMD_POLL;
      if (run_left == 0) begin
        finger_down = !finger_down;
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      // Sometimes land right on the debounce boundary of the current touch.
      if (finger_down && $urandom_range(0, 99) < 20)
        clock_ms = touch_start_ms + debounce_ms + $urandom_range(0, 1);
      else
        clock_ms = clock_ms + $urandom_range(0, 2 * int'(debounce_ms) + 2);
      it.now_ms = clock_ms;
      it.count = CNT_W'($urandom_range(0, 7));
      it.set_on = 1'($urandom_range(0, 1));
      live = (int'(it.count) > NUM_POINTS) ? NUM_POINTS : int'(it.count);
      if (finger_down) begin
        if (live == 0) begin
          it.count = CNT_W'($urandom_range(1, 7));
          live = (int'(it.count) > NUM_POINTS) ? NUM_POINTS : int'(it.count);
        end
        slot = $urandom_range(0, live - 1);
        it.px[slot] = coord_hit(box_left);
        it.py[slot] = coord_hit(box_top);
      end else if (live < NUM_POINTS && $urandom_range(0, 3) == 0) begin
        // A hit beyond the valid count must be ignored.
        slot = $urandom_range(live, NUM_POINTS - 1);
        it.px[slot] = coord_hit(box_left);
        it.py[slot] = coord_hit(box_top);
      end
    end
    return it;
  endfunction

  task automatic offer_poll(poll_t it, logic typed, tbd_result_t typed_res);
    tbd_result_t r;
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= pack_poll(it);
    do @(posedge clk); while (!in_tready);
    r = advance_button(it);
    if (typed) r = typed_res;
    results_due.push_back(r);
    items_sent++;
    // Each following cycle is left idle with the chosen probability.
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOX_LEFT: box_left = val[COORD_W-1:0];
      CFG_BOX_TOP:  box_top = val[COORD_W-1:0];
      CFG_LATCHING: latching = val[0];
      CFG_DEBOUNCE: debounce_ms = val[DEB_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // Output side: random back-pressure, plus one long hold-off on request.
  initial forever begin
    @(posedge clk);
    if (hold_off_req) begin
      out_tready <= 1'b0;
      hold_off_req = 1'b0;
      repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    tbd_result_t seen;
    tbd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[RESULT_W-1:0];
      if (results_due.size() == 0) begin
        $error("result %h arrived with no transaction outstanding", seen);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (seen.press_confirmed) confirmed_presses++;
        check_field("press_confirmed", int'(want.press_confirmed), int'(seen.press_confirmed));
        check_field("redraw", int'(want.redraw), int'(seen.redraw));
        check_field("tile_index", int'(want.tile_index), int'(seen.tile_index));
        check_field("beep_request", int'(want.beep_request), int'(seen.beep_request));
        check_field("indicator_on", int'(want.indicator_on), int'(seen.indicator_on));
        check_field("touched", int'(want.touched), int'(seen.touched));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("touch_button_debounce_fsm: mismatch");
      $finish;
    end
  end

  initial begin
    step_row_t         row;
    logic [COORD_W-1:0] bl;
    logic [COORD_W-1:0] bt;
    logic              latch;
    logic [DEB_W-1:0]  deb;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: box at the origin, momentary, 50 ms debounce.
    directed_rows.push_back(poll_row(32'd0, 3'd0, 0, 11'd0, 11'd0, 1'b1,
                                     outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(poll_row(32'd10, 3'd1, 0, 11'd0, 11'd0, 1'b1,
                                     outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b1)));
    // Elapsed equal to the debounce time is not yet enough.
    directed_rows.push_back(poll_row(32'd60, 3'd1, 0, 11'd80, 11'd80, 1'b1,
                                     outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b1)));
    directed_rows.push_back(poll_row(32'd61, 3'd2, 1, 11'd40, 11'd40, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd62, 3'd0, 0, 11'd40, 11'd40, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd100, 3'd4, 3, 11'd81, 11'd40, 1'b1,
                                     outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b0)));
    // More touches than points: the count is clipped, the last point still counts.
    directed_rows.push_back(poll_row(32'd200, 3'd7, 3, 11'd40, 11'd40, 1'b1,
                                     outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b1)));
    // Early release; the hit sits beyond the valid count.
    directed_rows.push_back(poll_row(32'd201, 3'd3, 3, 11'd40, 11'd40, 1'b0, '0));
    directed_rows.push_back(force_row(1'b1, 1'b1,
                                      outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(reg_row(CFG_LATCHING, 16'd1));
    directed_rows.push_back(force_row(1'b1, 1'b1,
                                      outcome(1'b0, 1'b1, TILE_IND, 1'b0, 1'b1, 1'b0)));
    directed_rows.push_back(poll_row(32'd1000, 3'd1, 0, 11'd0, 11'd0, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd1001, 3'd0, 0, 11'd0, 11'd0, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd2000, 3'd1, 0, 11'd80, 11'd0, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd2051, 3'd1, 0, 11'd0, 11'd80, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd2052, 3'd0, 0, 11'd0, 11'd0, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd3000, 3'd1, 0, 11'd10, 11'd10, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd3100, 3'd1, 0, 11'd10, 11'd10, 1'b0, '0));
    directed_rows.push_back(force_row(1'b0, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd3200, 3'd1, 0, 11'd10, 11'd10, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd3300, 3'd1, 0, 11'd10, 11'd10, 1'b0, '0));
    directed_rows.push_back(poll_row(32'd3301, 3'd0, 0, 11'd10, 11'd10, 1'b0, '0));
    // Box in the far corner, and a touch that spans the 32-bit time wrap.
    directed_rows.push_back(reg_row(CFG_BOX_LEFT, 16'd1967));
    directed_rows.push_back(reg_row(CFG_BOX_TOP, 16'd1967));
    directed_rows.push_back(force_row(1'b0, 1'b0, '0));
    directed_rows.push_back(poll_row(32'hFFFF_FFF0, 3'd1, 0, 11'd2047, 11'd2047, 1'b1,
                                     outcome(1'b0, 1'b0, TILE_NORMAL, 1'b0, 1'b0, 1'b1)));
    directed_rows.push_back(poll_row(32'h0000_0030, 3'd1, 0, 11'd1967, 11'd1967, 1'b1,
                                     outcome(1'b0, 1'b1, TILE_PRESSED, 1'b1, 1'b0, 1'b1)));
    directed_rows.push_back(poll_row(32'h0000_0031, 3'd1, 0, 11'd1966, 11'd2047, 1'b0, '0));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        wait_until_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_poll(row.item, row.typed, row.res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_until_idle();
      bl = COORD_W'($urandom_range(0, COORD_MAX));
      bt = COORD_W'($urandom_range(0, COORD_MAX));
      latch = 1'($urandom_range(0, 1));
      deb = DEB_W'($urandom_range(0, 100));
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      case (p)
        0: latch = 1'b0;
        1: begin
          tx_idle_pct = 46;
          latch = 1'b1;
          deb = 16'd0;
        end
        2: begin
          rx_stall_pct = 46;
          bl = COORD_W'(COORD_MAX);
          bt = COORD_W'(COORD_MAX);
          latch = 1'b1;
          deb = 16'hFFFF;
        end
        3: begin
          tx_idle_pct = 16;
          rx_stall_pct = 16;
          bl = '0;
          bt = '0;
          latch = 1'b0;
          deb = DEB_W'($urandom_range(0, 200));
        end
        4: begin
          latch = 1'b1;
          hold_off_req = 1'b1;
        end
        default: begin
          tx_idle_pct = 46;
          clock_ms = 32'hFFFF_0000;
          deb = DEB_W'($urandom_range(0, 300));
        end
      endcase
      write_reg(CFG_BOX_LEFT, CFG_DATA_W'(bl));
      write_reg(CFG_BOX_TOP, CFG_DATA_W'(bt));
      write_reg(CFG_LATCHING, CFG_DATA_W'(latch));
      write_reg(CFG_DEBOUNCE, deb);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) offer_poll(make_poll(), 1'b0, '0);
    end

    wait_until_idle();
    repeat (6) @(posedge clk);

    $display("Sent %0d transactions over %0d register settings: both button modes,",
             items_sent, NUM_PHASES + 1);
    $display("debounce 0 and 65535, corner boxes, time wrap; %0d results, %0d presses.",
             results_checked, confirmed_presses);
    if (mismatches == 0)
      $display("touch_button_debounce_fsm: match");
    else
      $display("touch_button_debounce_fsm: mismatch");
    $finish;
  end

endmodule
